// ----- rtl/detection_decode_and_nms_macros.svh -----
// Assertion helpers for the detection decode and suppression block.
`ifndef DETECTION_DECODE_AND_NMS_MACROS_SVH
`define DETECTION_DECODE_AND_NMS_MACROS_SVH
`ifndef SYNTHESIS
`define DDNMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define DDNMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DDNMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DDNMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/ddnms_pkg.sv -----
package ddnms_pkg;

    localparam int MAX_DETS_DEF = 64;
    localparam int NUM_CLASSES  = 4;
    localparam int OUT_LIMIT    = 64;
    localparam int PH_LAST      = 4;

    localparam logic [2:0] CFG_CONF_THR = 3'd0;
    localparam logic [2:0] CFG_OVL_THR  = 3'd1;
    localparam logic [2:0] CFG_ROI      = 3'd2;
    localparam logic [2:0] CFG_OFF_X    = 3'd3;
    localparam logic [2:0] CFG_OFF_Y    = 3'd4;
    localparam logic [2:0] CFG_FRAME_W  = 3'd5;
    localparam logic [2:0] CFG_FRAME_H  = 3'd6;

    localparam logic [15:0] RST_CONF_THR = 16'd16384;
    localparam logic [15:0] RST_OVL_THR  = 16'd29491;
    localparam logic [12:0] RST_ROI      = 13'd416;
    localparam logic [13:0] RST_FRAME_W  = 14'd1920;
    localparam logic [13:0] RST_FRAME_H  = 14'd1080;

    // 2.0 in Q15.8
    localparam logic signed [23:0] NORM_LIMIT = 24'sd512;

    typedef struct packed {
        logic        valid;
        logic        supp;
        logic [1:0]  cls;
        logic [15:0] score;
        logic [20:0] l;
        logic [20:0] r;
        logic [20:0] t;
        logic [20:0] b;
    } t_box;

    typedef struct packed {
        logic ins;
        logic rot;
        logic clr;
    } t_ctl;

    typedef struct packed {
        logic vld;
        logic last;
        logic keep;
        t_box box;
    } t_dec;

    // Clamp a Q.9 corner to [0, (size-1)*512] and drop the half LSB.
    function automatic logic [20:0] ddnms_corner(input logic signed [40:0] v,
                                                 input logic [13:0] size);
        logic [13:0] sz;
        logic [21:0] hi;
        logic [21:0] c;
        sz = (size == 14'd0) ? 14'd1 : ((size > 14'd8192) ? 14'd8192 : size);
        hi = {13'(sz - 14'd1), 9'd0};
        if (v < 0) begin
            c = 22'd0;
        end else if (v > $signed({19'd0, hi})) begin
            c = hi;
        end else begin
            c = v[21:0];
        end
        return c[21:1];
    endfunction

endpackage

// ----- rtl/ddnms_in_if.sv -----
interface ddnms_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] box_width;
    logic signed [23:0] box_height;
    logic [15:0]        score_class0;
    logic [15:0]        score_class1;
    logic [15:0]        score_class2;
    logic [15:0]        score_class3;
    logic               last_anchor;

    modport source (output valid, center_x, center_y, box_width, box_height,
                    score_class0, score_class1, score_class2, score_class3,
                    last_anchor, input ready);
    modport sink (input valid, center_x, center_y, box_width, box_height,
                  score_class0, score_class1, score_class2, score_class3,
                  last_anchor, output ready);
endinterface

// ----- rtl/ddnms_out_if.sv -----
interface ddnms_out_if;
    logic        valid;
    logic        ready;
    logic        det_valid;
    logic [20:0] left;
    logic [20:0] top;
    logic [20:0] right;
    logic [20:0] bottom;
    logic [15:0] det_score;
    logic [1:0]  det_class;
    logic [15:0] peak_score;
    logic        last_result;

    modport source (output valid, det_valid, left, top, right, bottom, det_score,
                    det_class, peak_score, last_result, input ready);
    modport sink (input valid, det_valid, left, top, right, bottom, det_score,
                  det_class, peak_score, last_result, output ready);
endinterface

// ----- rtl/ddnms_cell.sv -----
module ddnms_cell
    import ddnms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    input  t_box i_new,
    input  t_box i_prev,
    input  logic i_prev_keep,
    input  t_box i_next,
    output t_box o_box,
    output logic o_keep
);

    t_box r_box;

    // Hold the entry when it ranks at or above the newcomer.
    assign o_keep = r_box.valid && (r_box.score >= i_new.score);
    assign o_box  = r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.valid <= 1'b0;
            r_box.supp  <= 1'b0;
        end else if (i_ctl.clr) begin
            r_box.valid <= 1'b0;
            r_box.supp  <= 1'b0;
        end else if (i_ctl.ins) begin
            if (!o_keep) begin
                r_box <= i_prev_keep ? i_new : i_prev;
            end
        end else if (i_ctl.rot) begin
            r_box <= i_next;
        end
    end

endmodule

// ----- rtl/ddnms_iou.sv -----
module ddnms_iou
    import ddnms_pkg::*;
(
    input  logic        i_clk,
    input  t_box        i_a,
    input  t_box        i_b,
    input  logic [15:0] i_thr,
    output logic        o_hit
);

    logic [20:0] r_ox, r_oy, r_exa, r_eya, r_exb, r_eyb;
    logic [41:0] r_inter, r_aa, r_ab;
    logic [41:0] r_inter2;
    logic [42:0] r_uni;
    logic [41:0] r_inter3;
    logic [37:0] r_p_hi;
    logic [36:0] r_p_lo;

    logic [20:0] w_xlo, w_xhi, w_ylo, w_yhi;
    logic [59:0] w_lhs, w_rhs;

    assign w_xlo = (i_a.l > i_b.l) ? i_a.l : i_b.l;
    assign w_xhi = (i_a.r < i_b.r) ? i_a.r : i_b.r;
    assign w_ylo = (i_a.t > i_b.t) ? i_a.t : i_b.t;
    assign w_yhi = (i_a.b < i_b.b) ? i_a.b : i_b.b;

    always_ff @(posedge i_clk) begin
        r_ox  <= (w_xhi > w_xlo) ? w_xhi - w_xlo : 21'd0;
        r_oy  <= (w_yhi > w_ylo) ? w_yhi - w_ylo : 21'd0;
        r_exa <= (i_a.r > i_a.l) ? i_a.r - i_a.l : 21'd0;
        r_eya <= (i_a.b > i_a.t) ? i_a.b - i_a.t : 21'd0;
        r_exb <= (i_b.r > i_b.l) ? i_b.r - i_b.l : 21'd0;
        r_eyb <= (i_b.b > i_b.t) ? i_b.b - i_b.t : 21'd0;

        r_inter <= 42'(r_ox) * 42'(r_oy);
        r_aa    <= 42'(r_exa) * 42'(r_eya);
        r_ab    <= 42'(r_exb) * 42'(r_eyb);

        r_uni    <= 43'(r_aa) + 43'(r_ab) - 43'(r_inter);
        r_inter2 <= r_inter;

        // Split the threshold product into two partial products.
        r_p_hi   <= 38'(r_uni[42:21]) * 38'(i_thr);
        r_p_lo   <= 37'(r_uni[20:0]) * 37'(i_thr);
        r_inter3 <= r_inter2;
    end

    assign w_lhs = {2'd0, r_inter3, 16'd0};
    assign w_rhs = {1'b0, r_p_hi, 21'd0} + 60'(r_p_lo);
    assign o_hit = w_lhs > w_rhs;

endmodule

// ----- rtl/ddnms_decode.sv -----
module ddnms_decode
    import ddnms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  logic signed [23:0] i_cx,
    input  logic signed [23:0] i_cy,
    input  logic signed [23:0] i_w,
    input  logic signed [23:0] i_h,
    input  logic [15:0]        i_sc0,
    input  logic [15:0]        i_sc1,
    input  logic [15:0]        i_sc2,
    input  logic [15:0]        i_sc3,
    input  logic               i_last,
    input  logic [15:0]        i_conf_thr,
    input  logic [12:0]        i_roi,
    input  logic [12:0]        i_off_x,
    input  logic [12:0]        i_off_y,
    input  logic [13:0]        i_fw,
    input  logic [13:0]        i_fh,
    output logic               o_best_vld,
    output logic [15:0]        o_best,
    output t_dec               o_dec
);

    logic [15:0] w_sc [4];
    logic [15:0] w_best;
    logic [1:0]  w_cls;

    logic               r1_vld, r1_last, r1_keep, r1_norm;
    logic signed [23:0] r1_cx, r1_cy, r1_w, r1_h;
    logic [15:0]        r1_best;
    logic [1:0]         r1_cls;

    logic               r2_vld, r2_last, r2_keep;
    logic signed [37:0] r2_cx, r2_cy, r2_w, r2_h;
    logic [15:0]        r2_best;
    logic [1:0]         r2_cls;

    logic               r3_vld, r3_last, r3_keep;
    t_box               r3_box;

    logic signed [37:0] w_roi;
    logic signed [40:0] w_vl, w_vr, w_vt, w_vb, w_offx, w_offy;

    assign w_sc[0] = i_sc0;
    assign w_sc[1] = i_sc1;
    assign w_sc[2] = i_sc2;
    assign w_sc[3] = i_sc3;

    // Best class; ties keep the lower index.
    always_comb begin
        w_best = w_sc[0];
        w_cls  = 2'd0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (w_sc[c] > w_best) begin
                w_best = w_sc[c];
                w_cls  = 2'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_acc;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_last <= i_last;
        r1_keep <= w_best >= i_conf_thr;
        r1_norm <= (i_cx <= NORM_LIMIT) && (i_cy <= NORM_LIMIT) &&
                   (i_w <= NORM_LIMIT) && (i_h <= NORM_LIMIT);
        r1_cx   <= i_cx;
        r1_cy   <= i_cy;
        r1_w    <= i_w;
        r1_h    <= i_h;
        r1_best <= w_best;
        r1_cls  <= w_cls;
    end

    assign w_roi = 38'($signed({1'b0, i_roi}));

    always_ff @(posedge i_clk) begin
        r2_last <= r1_last;
        r2_keep <= r1_keep;
        r2_best <= r1_best;
        r2_cls  <= r1_cls;
        if (r1_norm) begin
            r2_cx <= 38'(r1_cx) * w_roi;
            r2_cy <= 38'(r1_cy) * w_roi;
            r2_w  <= 38'(r1_w) * w_roi;
            r2_h  <= 38'(r1_h) * w_roi;
        end else begin
            r2_cx <= 38'(r1_cx);
            r2_cy <= 38'(r1_cy);
            r2_w  <= 38'(r1_w);
            r2_h  <= 38'(r1_h);
        end
    end

    assign w_offx = 41'($signed({1'b0, i_off_x, 9'd0}));
    assign w_offy = 41'($signed({1'b0, i_off_y, 9'd0}));
    assign w_vl   = (41'(r2_cx) <<< 1) - 41'(r2_w) + w_offx;
    assign w_vr   = (41'(r2_cx) <<< 1) + 41'(r2_w) + w_offx;
    assign w_vt   = (41'(r2_cy) <<< 1) - 41'(r2_h) + w_offy;
    assign w_vb   = (41'(r2_cy) <<< 1) + 41'(r2_h) + w_offy;

    always_ff @(posedge i_clk) begin
        r3_last      <= r2_last;
        r3_keep      <= r2_keep;
        r3_box.valid <= 1'b1;
        r3_box.supp  <= 1'b0;
        r3_box.cls   <= r2_cls;
        r3_box.score <= r2_best;
        r3_box.l     <= ddnms_corner(w_vl, i_fw);
        r3_box.r     <= ddnms_corner(w_vr, i_fw);
        r3_box.t     <= ddnms_corner(w_vt, i_fh);
        r3_box.b     <= ddnms_corner(w_vb, i_fh);
    end

    assign o_best_vld = r1_vld;
    assign o_best     = r1_best;
    assign o_dec.vld  = r3_vld;
    assign o_dec.last = r3_last;
    assign o_dec.keep = r3_keep;
    assign o_dec.box  = r3_box;

endmodule

// ----- rtl/detection_decode_and_nms.sv -----
// Detection decode and class-wise suppression. Anchors stream in at one beat per
// clock while a frame is open; each is scored, decoded to a clamped corner box
// and, when its best score clears the confidence threshold, dropped into its
// ranked place in a row of MAX_DETS cells (equal scores keep arrival order, the
// lowest falls off the end). A beat with last_anchor set closes the frame: ready
// drops, the three decode stages drain, then the cell row rotates past a shared
// four-stage overlap unit one pair at a time, a full rotation for each of the
// MAX_DETS entries. Emission then rotates the row once more, pausing while the
// output is stalled, giving up to 64 result beats, the final one flagged with
// last_result, or a single beat with det_valid low if nothing survived. Ready
// returns once the final result sits in the output register. Configuration may
// be written only while no frame is open.
`include "detection_decode_and_nms_macros.svh"

module detection_decode_and_nms
    import ddnms_pkg::*;
#(
    parameter int MAX_DETS = MAX_DETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    ddnms_in_if.sink    i_anchor,
    ddnms_out_if.source o_det
);

    localparam int PW = $clog2(MAX_DETS + 1);
    localparam int JW = $clog2(2 * MAX_DETS + 1);
    localparam int NW = $clog2(OUT_LIMIT + 1);

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_WAIT  = 3'd1;
    localparam logic [2:0] ST_LATCH = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    // Configuration registers
    logic [15:0] r_conf_thr, r_ovl_thr;
    logic [12:0] r_roi, r_off_x, r_off_y;
    logic [13:0] r_fw, r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_thr <= RST_CONF_THR;
            r_ovl_thr  <= RST_OVL_THR;
            r_roi      <= RST_ROI;
            r_off_x    <= 13'd0;
            r_off_y    <= 13'd0;
            r_fw       <= RST_FRAME_W;
            r_fh       <= RST_FRAME_H;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CONF_THR: r_conf_thr <= i_cfg_data;
                CFG_OVL_THR:  r_ovl_thr  <= i_cfg_data;
                CFG_ROI:      r_roi      <= i_cfg_data[12:0];
                CFG_OFF_X:    r_off_x    <= i_cfg_data[12:0];
                CFG_OFF_Y:    r_off_y    <= i_cfg_data[12:0];
                CFG_FRAME_W:  r_fw       <= i_cfg_data[13:0];
                CFG_FRAME_H:  r_fh       <= i_cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

    // Control state
    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_pass, n_pass;
    logic [PW-1:0] r_step, n_step;
    logic [JW-1:0] r_j, n_j;
    logic [2:0]    r_phase, n_phase;
    logic [PW-1:0] r_scan, n_scan;
    logic [NW-1:0] r_nemit, n_nemit;
    logic [15:0]   r_peak, n_peak;
    t_box          r_ref, n_ref;
    logic          r_pv, n_pv;
    t_box          r_pend, n_pend;
    logic          r_ov, n_ov;
    t_box          r_obox, n_obox;
    logic          r_olast, n_olast;
    logic [15:0]   r_opeak, n_opeak;

    logic          w_acc, w_best_vld, w_hit, w_hit_en, w_out_free, w_emit_ok, w_emit_go;
    logic [15:0]   w_best;
    t_dec          w_dec;
    t_ctl          w_ctl;
    t_box          w_box [MAX_DETS];
    logic          w_keep [MAX_DETS];
    t_box          w_wrap, w_c0, w_empty;

    assign i_anchor.ready = (r_state == ST_RUN);
    assign w_acc          = i_anchor.valid && i_anchor.ready;

    ddnms_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_cx       (i_anchor.center_x),
        .i_cy       (i_anchor.center_y),
        .i_w        (i_anchor.box_width),
        .i_h        (i_anchor.box_height),
        .i_sc0      (i_anchor.score_class0),
        .i_sc1      (i_anchor.score_class1),
        .i_sc2      (i_anchor.score_class2),
        .i_sc3      (i_anchor.score_class3),
        .i_last     (i_anchor.last_anchor),
        .i_conf_thr (r_conf_thr),
        .i_roi      (r_roi),
        .i_off_x    (r_off_x),
        .i_off_y    (r_off_y),
        .i_fw       (r_fw),
        .i_fh       (r_fh),
        .o_best_vld (w_best_vld),
        .o_best     (w_best),
        .o_dec      (w_dec)
    );

    assign w_c0 = w_box[0];

    // Shared overlap unit: the reference box against whatever sits in cell 0.
    ddnms_iou u_iou (
        .i_clk (i_clk),
        .i_a   (r_ref),
        .i_b   (w_c0),
        .i_thr (r_ovl_thr),
        .o_hit (w_hit)
    );

    // Suppress only later, live boxes of the same class, and only from a live reference.
    assign w_hit_en = (r_state == ST_CMP) && (r_phase == 3'(PH_LAST)) &&
                      (r_j < JW'(MAX_DETS)) && w_c0.valid && !w_c0.supp &&
                      r_ref.valid && !r_ref.supp && (r_ref.cls == w_c0.cls) && w_hit;

    always_comb begin
        w_wrap      = w_c0;
        w_wrap.supp = w_c0.supp | w_hit_en;
    end

    assign w_out_free = !r_ov || o_det.ready;
    assign w_emit_ok  = w_c0.valid && !w_c0.supp && (r_nemit < NW'(OUT_LIMIT));
    assign w_emit_go  = !w_emit_ok || !r_pv || w_out_free;

    assign w_ctl.ins = w_dec.vld && w_dec.keep;
    assign w_ctl.rot = (r_state == ST_LATCH) ||
                       ((r_state == ST_CMP) && (r_phase == 3'(PH_LAST))) ||
                       ((r_state == ST_EMIT) && w_emit_go);
    assign w_ctl.clr = (r_state == ST_FLUSH) && w_out_free;

    // The ranked row of cells: insert shifts down, rotate shifts towards cell 0.
    for (genvar k = 0; k < MAX_DETS; k++) begin : g_cell
        t_box w_prev, w_next;
        logic w_pk;
        if (k == 0) begin : g_head
            assign w_prev = w_box[0];
            assign w_pk   = 1'b1;
        end else begin : g_body
            assign w_prev = w_box[k-1];
            assign w_pk   = w_keep[k-1];
        end
        if (k == MAX_DETS - 1) begin : g_tail
            assign w_next = w_wrap;
        end else begin : g_mid
            assign w_next = w_box[k+1];
        end
        ddnms_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new       (w_dec.box),
            .i_prev      (w_prev),
            .i_prev_keep (w_pk),
            .i_next      (w_next),
            .o_box       (w_box[k]),
            .o_keep      (w_keep[k])
        );
    end

    always_comb begin
        w_empty = '0;
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_step  = r_step;
        n_j     = r_j;
        n_phase = r_phase;
        n_scan  = r_scan;
        n_nemit = r_nemit;
        n_peak  = r_peak;
        n_ref   = r_ref;
        n_pv    = r_pv;
        n_pend  = r_pend;
        n_ov    = r_ov && !o_det.ready;
        n_obox  = r_obox;
        n_olast = r_olast;
        n_opeak = r_opeak;

        // Track the frame's peak best score, below threshold too.
        if (w_best_vld && (w_best > r_peak)) begin
            n_peak = w_best;
        end

        case (r_state)
            ST_RUN: begin
                if (w_acc && i_anchor.last_anchor) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // Hold until the closing anchor has left the decode stages and, if kept, been inserted.
                if (w_dec.vld && w_dec.last) begin
                    n_state = ST_LATCH;
                    n_pass  = '0;
                end
            end
            ST_LATCH: begin
                n_ref   = w_c0;
                n_step  = '0;
                n_j     = JW'(r_pass) + JW'(1);
                n_phase = '0;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_phase == 3'(PH_LAST)) begin
                    n_phase = '0;
                    n_step  = r_step + PW'(1);
                    n_j     = r_j + JW'(1);
                    if (r_step == PW'(MAX_DETS - 1)) begin
                        if (r_pass == PW'(MAX_DETS - 1)) begin
                            n_state = ST_EMIT;
                            n_scan  = '0;
                            n_nemit = '0;
                            n_pv    = 1'b0;
                        end else begin
                            n_pass  = r_pass + PW'(1);
                            n_state = ST_LATCH;
                        end
                    end
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            ST_EMIT: begin
                // Keep one survivor back so the final beat can carry last_result.
                if (w_emit_go) begin
                    n_scan = r_scan + PW'(1);
                    if (r_scan == PW'(MAX_DETS - 1)) begin
                        n_state = ST_FLUSH;
                    end
                    if (w_emit_ok) begin
                        n_nemit = r_nemit + NW'(1);
                        n_pend  = w_c0;
                        n_pv    = 1'b1;
                        if (r_pv) begin
                            n_ov    = 1'b1;
                            n_obox  = r_pend;
                            n_olast = 1'b0;
                            n_opeak = r_peak;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_obox  = r_pv ? r_pend : w_empty;
                    n_olast = 1'b1;
                    n_opeak = r_peak;
                    n_pv    = 1'b0;
                    n_peak  = '0;
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_pass  <= '0;
            r_step  <= '0;
            r_j     <= '0;
            r_phase <= '0;
            r_scan  <= '0;
            r_nemit <= '0;
            r_peak  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_step  <= n_step;
            r_j     <= n_j;
            r_phase <= n_phase;
            r_scan  <= n_scan;
            r_nemit <= n_nemit;
            r_peak  <= n_peak;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ref   <= n_ref;
        r_pend  <= n_pend;
        r_obox  <= n_obox;
        r_olast <= n_olast;
        r_opeak <= n_opeak;
    end

    assign o_det.valid       = r_ov;
    assign o_det.det_valid   = r_obox.valid;
    assign o_det.left        = r_obox.l;
    assign o_det.top         = r_obox.t;
    assign o_det.right       = r_obox.r;
    assign o_det.bottom      = r_obox.b;
    assign o_det.det_score   = r_obox.score;
    assign o_det.det_class   = r_obox.cls;
    assign o_det.peak_score  = r_opeak;
    assign o_det.last_result = r_olast;

    // A closing anchor shuts the input until the frame's results are out.
    `DDNMS_ASSERT_NXT(a_close_frame, i_clk, i_rst_n, w_acc && i_anchor.last_anchor, !i_anchor.ready, "input still open after the closing anchor")
    // An empty result only ever appears as the frame's final beat.
    `DDNMS_ASSERT_IMP(a_empty_is_last, i_clk, i_rst_n, o_det.valid && !o_det.det_valid, o_det.last_result, "empty result not flagged last")
    // Flushing a frame always presents a final beat.
    `DDNMS_ASSERT_NXT(a_flush_last, i_clk, i_rst_n, (r_state == ST_FLUSH) && w_out_free, o_det.valid && o_det.last_result, "flush did not present the final beat")

endmodule

// ----- tb/tb_detection_decode_and_nms.sv -----
`timescale 1ns / 1ps

module tb_detection_decode_and_nms;
    import ddnms_pkg::*;

    localparam int STORE_DEPTH = 64;

    // One anchor beat as the network memory would stream it
    typedef struct {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] w;
        logic signed [23:0] h;
        logic [15:0]        sc [4];
        logic               last;
    } t_anchor;

    // One detection beat on the output channel
    typedef struct {
        logic        dv;
        logic [20:0] l;
        logic [20:0] t;
        logic [20:0] r;
        logic [20:0] b;
        logic [15:0] score;
        logic [1:0]  cls;
        logic [15:0] peak;
        logic        last;
    } t_det;

    // A ranked box as held between anchors of one frame
    typedef struct {
        logic [20:0] l;
        logic [20:0] r;
        logic [20:0] t;
        logic [20:0] b;
        logic [15:0] score;
        logic [1:0]  cls;
    } t_rank_box;

    // Directed stimulus row; typed rows carry the single result of their frame
    typedef struct {
        t_anchor a;
        bit      typed;
        t_det    d;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    ddnms_in_if  anc_if ();
    ddnms_out_if det_if ();

    detection_decode_and_nms u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_anchor   (anc_if),
        .o_det      (det_if)
    );

    // Shadow copy of the register file
    logic [15:0] conf_thr;
    logic [15:0] ovl_thr;
    logic [12:0] roi;
    logic [12:0] off_x;
    logic [12:0] off_y;
    logic [13:0] frame_w;
    logic [13:0] frame_h;

    // Shadow copy of the ranked box row for the open frame
    t_rank_box   ranked [STORE_DEPTH];
    int          n_ranked;
    logic [15:0] frame_peak;

    t_det expected_dets [$];
    int   errors;
    int   snd_idle;
    int   rcv_stall;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp a Q.9 corner into the frame, then drop the half LSB
    function automatic logic [20:0] clamp_corner(longint v, int size);
        int     sz;
        longint hi;
        sz = (size == 0) ? 1 : ((size > 8192) ? 8192 : size);
        hi = longint'(sz - 1) * 512;
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return 21'(v >>> 1);
    endfunction

    // Positive length between two coordinates, zero when inverted
    function automatic longint unsigned span(logic [20:0] lo, logic [20:0] hi);
        return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    // Overlap test done by cross-multiplication, no divide
    function automatic bit overlaps_too_much(t_rank_box a, t_rank_box b);
        longint unsigned ix, iy, inter, area_a, area_b, uni;
        ix = span((a.l > b.l) ? a.l : b.l, (a.r < b.r) ? a.r : b.r);
        iy = span((a.t > b.t) ? a.t : b.t, (a.b < b.b) ? a.b : b.b);
        inter  = ix * iy;
        area_a = span(a.l, a.r) * span(a.t, a.b);
        area_b = span(b.l, b.r) * span(b.t, b.b);
        uni    = area_a + area_b - inter;
        return (inter << 16) > longint'(ovl_thr) * uni;
    endfunction

    // Suppress within class, emit the survivors and open a fresh frame
    task automatic close_frame();
        bit   supp [STORE_DEPTH];
        int   n_out;
        t_det d;
        n_out = 0;
        for (int i = 0; i < STORE_DEPTH; i++) supp[i] = 1'b0;
        for (int i = 0; i < n_ranked; i++) begin
            if (supp[i]) continue;
            for (int j = i + 1; j < n_ranked; j++) begin
                if (supp[j] || ranked[i].cls != ranked[j].cls) continue;
                if (overlaps_too_much(ranked[i], ranked[j])) supp[j] = 1'b1;
            end
        end
        for (int i = 0; i < n_ranked && n_out < OUT_LIMIT; i++) begin
            if (supp[i]) continue;
            d = '{1'b1, ranked[i].l, ranked[i].t, ranked[i].r, ranked[i].b,
                  ranked[i].score, ranked[i].cls, frame_peak, 1'b0};
            expected_dets = {expected_dets, d};
            n_out++;
        end
        // Nothing survived: one empty beat carrying just the peak
        if (n_out == 0) begin
            d = '{1'b0, 21'd0, 21'd0, 21'd0, 21'd0, 16'd0, 2'd0, frame_peak, 1'b0};
            expected_dets = {expected_dets, d};
        end
        expected_dets[expected_dets.size() - 1].last = 1'b1;
        n_ranked   = 0;
        frame_peak = 16'd0;
    endtask

    // Score, decode and rank one accepted anchor
    task automatic rank_anchor(t_anchor a);
        logic [15:0] best;
        logic [1:0]  cls;
        longint      cx, cy, w, h;
        t_rank_box   nb;
        int          pos;
        best = a.sc[0];
        cls  = 2'd0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (a.sc[c] > best) begin
                best = a.sc[c];
                cls  = 2'(c);
            end
        end
        if (best > frame_peak) frame_peak = best;
        if (best >= conf_thr) begin
            cx = a.cx;
            cy = a.cy;
            w  = a.w;
            h  = a.h;
            // Normalised geometry: every value at most 2.0
            if (cx <= 512 && cy <= 512 && w <= 512 && h <= 512) begin
                cx = cx * longint'(roi);
                cy = cy * longint'(roi);
                w  = w * longint'(roi);
                h  = h * longint'(roi);
            end
            nb.l     = clamp_corner(2 * cx - w + longint'(off_x) * 512, int'(frame_w));
            nb.r     = clamp_corner(2 * cx + w + longint'(off_x) * 512, int'(frame_w));
            nb.t     = clamp_corner(2 * cy - h + longint'(off_y) * 512, int'(frame_h));
            nb.b     = clamp_corner(2 * cy + h + longint'(off_y) * 512, int'(frame_h));
            nb.score = best;
            nb.cls   = cls;
            // Equal scores keep arrival order; a full row drops its lowest
            pos = 0;
            while (pos < n_ranked && ranked[pos].score >= best) pos++;
            if (pos < STORE_DEPTH) begin
                for (int k = (n_ranked < STORE_DEPTH) ? n_ranked : STORE_DEPTH - 1;
                     k > pos; k--) begin
                    ranked[k] = ranked[k - 1];
                end
                ranked[pos] = nb;
                if (n_ranked < STORE_DEPTH) n_ranked++;
            end
        end
        if (a.last) close_frame();
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and field-by-field comparison
    // ------------------------------------------------------------------

    task automatic report(string name, longint e, longint got);
        if (e != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            det_if.ready <= 1'b0;
        end else begin
            if (det_if.valid && det_if.ready) begin
                if (expected_dets.size() == 0) begin
                    $display("%0t: unexpected detection beat, expected none, actual score %0d",
                             $time, det_if.det_score);
                    errors++;
                end else begin
                    t_det e;
                    e = expected_dets.pop_front();
                    report("det_valid", e.dv, det_if.det_valid);
                    report("left", e.l, det_if.left);
                    report("top", e.t, det_if.top);
                    report("right", e.r, det_if.right);
                    report("bottom", e.b, det_if.bottom);
                    report("det_score", e.score, det_if.det_score);
                    report("det_class", e.cls, det_if.det_class);
                    report("peak_score", e.peak, det_if.peak_score);
                    report("last_result", e.last, det_if.last_result);
                end
            end
            det_if.ready <= ($urandom_range(99) >= rcv_stall);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    function automatic t_anchor mk(int cx, int cy, int w, int h,
                                   int s0, int s1, int s2, int s3, bit last);
        t_anchor a;
        a.cx    = 24'(cx);
        a.cy    = 24'(cy);
        a.w     = 24'(w);
        a.h     = 24'(h);
        a.sc[0] = 16'(s0);
        a.sc[1] = 16'(s1);
        a.sc[2] = 16'(s2);
        a.sc[3] = 16'(s3);
        a.last  = last;
        return a;
    endfunction

    // Present one beat and hold it until the block takes it
    task automatic send_anchor(t_anchor a);
        while ($urandom_range(99) < snd_idle) begin
            anc_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        anc_if.valid        <= 1'b1;
        anc_if.center_x     <= a.cx;
        anc_if.center_y     <= a.cy;
        anc_if.box_width    <= a.w;
        anc_if.box_height   <= a.h;
        anc_if.score_class0 <= a.sc[0];
        anc_if.score_class1 <= a.sc[1];
        anc_if.score_class2 <= a.sc[2];
        anc_if.score_class3 <= a.sc[3];
        anc_if.last_anchor  <= a.last;
        @(posedge i_clk);
        while (!anc_if.ready) @(posedge i_clk);
        rank_anchor(a);
    endtask

    // Drain the frame in flight, then let the output stage settle
    task automatic wait_idle();
        anc_if.valid <= 1'b0;
        while (expected_dets.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Drive one register write; the caller drops the write enable
    task automatic write_reg(logic [2:0] idx, int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 16'(val);
        case (idx)
            CFG_CONF_THR: conf_thr = 16'(val);
            CFG_OVL_THR:  ovl_thr  = 16'(val);
            CFG_ROI:      roi      = 13'(val);
            CFG_OFF_X:    off_x    = 13'(val);
            CFG_OFF_Y:    off_y    = 13'(val);
            CFG_FRAME_W:  frame_w  = 14'(val);
            CFG_FRAME_H:  frame_h  = 14'(val);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(int ct, int ot, int rs, int ox, int oy, int fw, int fh);
        write_reg(CFG_CONF_THR, ct);
        write_reg(CFG_OVL_THR, ot);
        write_reg(CFG_ROI, rs);
        write_reg(CFG_OFF_X, ox);
        write_reg(CFG_OFF_Y, oy);
        write_reg(CFG_FRAME_W, fw);
        write_reg(CFG_FRAME_H, fh);
        i_cfg_we <= 1'b0;
    endtask

    // Random geometry in one of three styles: normalised, pixel or raw
    function automatic int rand_coord(int style, bit is_size);
        case (style)
            0:       return is_size ? $urandom_range(0, 512) : $urandom_range(0, 1024) - 512;
            1:       return is_size ? $urandom_range(0, 200 * 256)
                                    : $urandom_range(0, 2100 * 256);
            default: return int'($urandom);
        endcase
    endfunction

    // Random frames; most anchors cluster round one box so suppression bites
    task automatic random_frames(int n_items, int first_len);
        int      sent, len, style, fav, bx, by, bw, bh;
        t_anchor a;
        sent = 0;
        while (sent < n_items) begin
            len   = (first_len > 0 && sent == 0) ? first_len : $urandom_range(1, 12);
            style = $urandom_range(0, 2);
            fav   = $urandom_range(0, 3);
            bx    = rand_coord(style, 1'b0);
            by    = rand_coord(style, 1'b0);
            bw    = rand_coord(style, 1'b1);
            bh    = rand_coord(style, 1'b1);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(99) < 60) begin
                    a = mk(bx + $urandom_range(0, 16) - 8, by + $urandom_range(0, 16) - 8,
                           bw + $urandom_range(0, 16) - 8, bh + $urandom_range(0, 16) - 8,
                           0, 0, 0, 0, k == len - 1);
                end else begin
                    a = mk(rand_coord(style, 1'b0), rand_coord(style, 1'b0),
                           rand_coord(style, 1'b1), rand_coord(style, 1'b1),
                           0, 0, 0, 0, k == len - 1);
                end
                for (int c = 0; c < 4; c++) begin
                    a.sc[c] = ($urandom_range(99) < 25) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 30000));
                end
                if ($urandom_range(99) < 70) a.sc[fav] = 16'($urandom_range(20000, 65535));
                send_anchor(a);
                sent++;
            end
        end
    endtask

    initial begin
        t_row dir_rows [$];
        t_row row;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_CONF_THR;
        i_cfg_data   <= 16'd0;
        anc_if.valid <= 1'b0;
        anc_if.center_x     <= '0;
        anc_if.center_y     <= '0;
        anc_if.box_width    <= '0;
        anc_if.box_height   <= '0;
        anc_if.score_class0 <= '0;
        anc_if.score_class1 <= '0;
        anc_if.score_class2 <= '0;
        anc_if.score_class3 <= '0;
        anc_if.last_anchor  <= 1'b0;
        errors     = 0;
        snd_idle   = 0;
        rcv_stall  = 0;
        n_ranked   = 0;
        frame_peak = 16'd0;
        conf_thr   = RST_CONF_THR;
        ovl_thr    = RST_OVL_THR;
        roi        = RST_ROI;
        off_x      = 13'd0;
        off_y      = 13'd0;
        frame_w    = RST_FRAME_W;
        frame_h    = RST_FRAME_H;

        // Directed rows. Typed ones are single-anchor frames whose result is obvious.
        // Zero box on the top class at full score
        row = '{mk(0, 0, 0, 0, 0, 0, 0, 65535, 1'b1), 1'b1,
                '{1'b1, 21'd0, 21'd0, 21'd0, 21'd0, 16'd65535, 2'd3, 16'd65535, 1'b1}};
        dir_rows = {dir_rows, row};
        // Empty frame, nothing scored at all
        row = '{mk(0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
                '{1'b0, 21'd0, 21'd0, 21'd0, 21'd0, 16'd0, 2'd0, 16'd0, 1'b1}};
        dir_rows = {dir_rows, row};
        // Empty frame, best score one below threshold still sets the peak
        row = '{mk(100, 100, 50, 50, 100, 16383, 5, 0, 1'b1), 1'b1,
                '{1'b0, 21'd0, 21'd0, 21'd0, 21'd0, 16'd0, 2'd0, 16'd16383, 1'b1}};
        dir_rows = {dir_rows, row};
        // Far corner: clamps to frame edge minus one; four-way tie goes to class 0
        row = '{mk(8388607, 8388607, 0, 0, 65535, 65535, 65535, 65535, 1'b1), 1'b1,
                '{1'b1, 21'd491264, 21'd276224, 21'd491264, 21'd276224,
                  16'd65535, 2'd0, 16'd65535, 1'b1}};
        dir_rows = {dir_rows, row};
        // Most negative centre with huge size: everything clamps to zero
        row = '{mk(-8388608, -8388608, 8388607, 8388607, 0, 40000, 0, 0, 1'b1), 1'b1,
                '{1'b1, 21'd0, 21'd0, 21'd0, 21'd0, 16'd40000, 2'd1, 16'd40000, 1'b1}};
        dir_rows = {dir_rows, row};
        // Mixed frame, checked by the predictor
        row.typed = 1'b0;
        row.a = mk(25600, 25600, 5120, 5120, 0, 0, 50000, 0, 1'b0);  // kept
        dir_rows = {dir_rows, row};
        row.a = mk(25856, 25600, 5120, 5120, 0, 0, 50000, 0, 1'b0);  // equal score, overlaps
        dir_rows = {dir_rows, row};
        row.a = mk(25600, 25600, 5120, 5120, 0, 60000, 0, 0, 1'b0);  // other class survives
        dir_rows = {dir_rows, row};
        row.a = mk(512, 512, 512, 512, 16384, 0, 0, 0, 1'b0);        // exactly 2.0, at threshold
        dir_rows = {dir_rows, row};
        row.a = mk(513, 0, 100, 100, 30000, 0, 0, 0, 1'b0);          // just above 2.0, unscaled
        dir_rows = {dir_rows, row};
        row.a = mk(50000, 50000, -2560, 2560, 0, 0, 0, 20000, 1'b0); // inverted width
        dir_rows = {dir_rows, row};
        row.a = mk(-512, -512, -512, -512, 0, 0, 16384, 0, 1'b0);    // negative normalised
        dir_rows = {dir_rows, row};
        row.a = mk(7000, 7000, 300, 300, 16383, 0, 0, 0, 1'b1);      // below threshold, closes
        dir_rows = {dir_rows, row};
        // Zero-area boxes of one class: union zero, never suppressed
        row.a = mk(30000, 30000, 0, 0, 50000, 0, 0, 0, 1'b0);
        dir_rows = {dir_rows, row};
        row.a = mk(30000, 30000, 0, 0, 50000, 0, 0, 0, 1'b1);
        dir_rows = {dir_rows, row};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            send_anchor(dir_rows[n].a);
            // Swap the predicted beat for the hand-written one
            if (dir_rows[n].typed) begin
                void'(expected_dets.pop_back());
                expected_dets = {expected_dets, dir_rows[n].d};
            end
        end

        // Random phases, each with a register setting and one of four idling patterns
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            case (p)
                0: ;
                1: configure(0, 0, 1, 0, 0, 8192, 8192);
                2: configure(65535, 65535, 4096, 8191, 8191, 1, 1);
                3: configure(30000, 32768, 0, 100, 50, 0, 16383);
                4: configure(8000, 20000, 8191, 3, 7, 640, 480);
                default: configure($urandom, $urandom, $urandom_range(1, 4096),
                                   $urandom_range(0, 8191), $urandom_range(0, 8191),
                                   $urandom_range(1, 8192), $urandom_range(1, 8192));
            endcase
            case (p % 4)
                0: begin snd_idle = 0;  rcv_stall = 0;  end
                1: begin snd_idle = 60; rcv_stall = 0;  end
                2: begin snd_idle = 0;  rcv_stall = 60; end
                default: begin snd_idle = 17; rcv_stall = 17; end
            endcase
            // With threshold zero every anchor is kept: overfill the row once
            random_frames((p == 1) ? 90 : 12, (p == 1) ? 70 : 0);
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ddnms_pkg.sv
rtl/ddnms_in_if.sv
rtl/ddnms_out_if.sv
rtl/ddnms_cell.sv
rtl/ddnms_iou.sv
rtl/ddnms_decode.sv
rtl/detection_decode_and_nms.sv
tb/tb_detection_decode_and_nms.sv
